// ----- rtl/atad_pkg.sv -----
package atad_pkg;

    localparam int AxisW      = 16;
    localparam int AngleW     = 16;
    localparam int RootW      = 24;
    localparam int RadW       = 2 * RootW;
    localparam int VecW       = 28;
    localparam int AccW       = 25;
    localparam int AtanLen    = 24;
    localparam int DefStages  = 16;
    localparam int AngleLimit = 23040;

    localparam logic [21:0] ATAN_Q16 [AtanLen] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    typedef struct packed {
        logic                     cmd;
        logic                     zero;
        logic signed [AxisW-1:0]  x;
    } side_t;

endpackage

// ----- rtl/atad_sample_if.sv -----
interface atad_sample_if
    import atad_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [AxisW-1:0] accel_x;
    logic signed [AxisW-1:0] accel_y;
    logic signed [AxisW-1:0] accel_z;

    modport source (output valid, command, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, command, accel_x, accel_y, accel_z, output ready);
endinterface

// ----- rtl/atad_result_if.sv -----
interface atad_result_if
    import atad_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [AngleW-1:0] tilt_angle;
    logic        [AngleW-1:0] delta_angle;

    modport source (output valid, tilt_angle, delta_angle, input ready);
    modport sink   (input valid, tilt_angle, delta_angle, output ready);
endinterface

// ----- rtl/accel_tilt_angle_delta.sv -----
// Pipeline: one square stage, one sum stage, 24 root stages, the CORDIC stages
// (CORDIC_STAGES, capped at 24), one rounding stage and one output stage.
// Throughput: one request per cycle while the result is taken; the slowest stage is the 48-bit
// subtract and compare of each square root step.
// Reset clears all valid bits and the reference angle to zero.
module accel_tilt_angle_delta
    import atad_pkg::*;
#(
    parameter int CORDIC_STAGES = DefStages
)
(
    input  logic          clk,
    input  logic          rst_n,
    atad_sample_if.sink   sample,
    atad_result_if.source result
);

    localparam int NStg = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;

    logic en;
    logic out_valid_reg;

    assign en           = !out_valid_reg || result.ready;
    assign sample.ready = en;

    // square stage
    logic                p_valid_reg;
    side_t               p_side_reg;
    logic [2*AxisW-2:0]  p_ysq_reg;
    logic [2*AxisW-2:0]  p_zsq_reg;
    side_t               p_side_next;
    logic signed [2*AxisW-1:0] ysq_full;
    logic signed [2*AxisW-1:0] zsq_full;

    always_comb
    begin
        ysq_full         = sample.accel_y * sample.accel_y;
        zsq_full         = sample.accel_z * sample.accel_z;
        p_side_next.cmd  = sample.command;
        p_side_next.x    = sample.accel_x;
        p_side_next.zero = (sample.accel_x == '0) && (sample.accel_y == '0)
                           && (sample.accel_z == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= p_side_next;
            p_ysq_reg  <= ysq_full[2*AxisW-2:0];
            p_zsq_reg  <= zsq_full[2*AxisW-2:0];
        end
    end

    // square root stages, one result bit each, MSB first
    logic              q_valid_reg [RootW+1];
    side_t             q_side_reg  [RootW+1];
    logic [RadW-1:0]   q_rem_reg   [RootW+1];
    logic [RootW-1:0]  q_root_reg  [RootW+1];
    logic [2*AxisW-1:0] sq_sum;

    assign sq_sum = {1'b0, p_ysq_reg} + {1'b0, p_zsq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            q_valid_reg[0] <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_side_reg[0] <= p_side_reg;
            q_rem_reg[0]  <= {sq_sum, 16'd0};
            q_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < RootW; k++)
    begin : g_root
        localparam int B = RootW - 1 - k;
        logic [RadW-1:0]  trial;
        logic             take;
        logic [RadW-1:0]  rem_next;
        logic [RootW-1:0] root_next;

        always_comb
        begin
            trial     = ({{(RadW-RootW){1'b0}}, q_root_reg[k]} << (B + 1))
                        + (RadW'(1) << (2 * B));
            take      = q_rem_reg[k] >= trial;
            rem_next  = take ? (q_rem_reg[k] - trial) : q_rem_reg[k];
            root_next = take ? (q_root_reg[k] | (RootW'(1) << B)) : q_root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                q_valid_reg[k+1] <= q_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_side_reg[k+1] <= q_side_reg[k];
                q_rem_reg[k+1]  <= rem_next;
                q_root_reg[k+1] <= root_next;
            end
        end
    end

    // CORDIC vectoring stages
    logic                   c_valid_reg [NStg+1];
    side_t                  c_side_reg  [NStg+1];
    logic signed [VecW-1:0] c_x_reg     [NStg+1];
    logic signed [VecW-1:0] c_y_reg     [NStg+1];
    logic signed [AccW-1:0] c_acc_reg   [NStg+1];

    always_comb
    begin
        c_valid_reg[0] = q_valid_reg[RootW];
        c_side_reg[0]  = q_side_reg[RootW];
        c_x_reg[0]     = VecW'($signed({1'b0, q_root_reg[RootW]}));
        c_y_reg[0]     = VecW'($signed({q_side_reg[RootW].x, 8'd0}));
        c_acc_reg[0]   = '0;
    end

    for (genvar i = 0; i < NStg; i++)
    begin : g_cordic
        logic signed [VecW-1:0] dx;
        logic signed [VecW-1:0] dy;
        logic signed [AccW-1:0] step;
        logic signed [VecW-1:0] x_next;
        logic signed [VecW-1:0] y_next;
        logic signed [AccW-1:0] acc_next;

        always_comb
        begin
            dx   = c_y_reg[i] >>> i;
            dy   = c_x_reg[i] >>> i;
            step = AccW'($signed({1'b0, ATAN_Q16[i]}));
            if (!c_y_reg[i][VecW-1])
            begin
                x_next   = c_x_reg[i] + dx;
                y_next   = c_y_reg[i] - dy;
                acc_next = c_acc_reg[i] + step;
            end
            else
            begin
                x_next   = c_x_reg[i] - dx;
                y_next   = c_y_reg[i] + dy;
                acc_next = c_acc_reg[i] - step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                c_valid_reg[i+1] <= c_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_side_reg[i+1] <= c_side_reg[i];
                c_x_reg[i+1]    <= x_next;
                c_y_reg[i+1]    <= y_next;
                c_acc_reg[i+1]  <= acc_next;
            end
        end
    end

    // round half up, saturate, zero for an all-zero sample
    logic                      f_valid_reg;
    logic                      f_cmd_reg;
    logic signed [AngleW-1:0]  f_angle_reg;
    logic signed [AccW-1:0]    acc_rnd;
    logic signed [AccW-9:0]    ang_wide;
    logic signed [AngleW-1:0]  f_angle_next;

    always_comb
    begin
        acc_rnd  = c_acc_reg[NStg] + AccW'(128);
        ang_wide = acc_rnd[AccW-1:8];
        if (c_side_reg[NStg].zero)
        begin
            f_angle_next = '0;
        end
        else if (ang_wide > (AccW-8)'(AngleLimit))
        begin
            f_angle_next = AngleW'(AngleLimit);
        end
        else if (ang_wide < -(AccW-8)'(AngleLimit))
        begin
            f_angle_next = -AngleW'(AngleLimit);
        end
        else
        begin
            f_angle_next = ang_wide[AngleW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= c_valid_reg[NStg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_cmd_reg   <= c_side_reg[NStg].cmd;
            f_angle_reg <= f_angle_next;
        end
    end

    // reference and delta
    logic signed [AngleW-1:0] ref_reg;
    logic signed [AngleW-1:0] tilt_reg;
    logic        [AngleW-1:0] delta_reg;
    logic                     cap_reg;
    logic signed [AngleW:0]   diff;
    logic        [AngleW-1:0] delta_next;

    always_comb
    begin
        diff = {f_angle_reg[AngleW-1], f_angle_reg} - {ref_reg[AngleW-1], ref_reg};
        if (f_cmd_reg)
        begin
            delta_next = '0;
        end
        else if (diff[AngleW])
        begin
            delta_next = AngleW'(-diff);
        end
        else
        begin
            delta_next = diff[AngleW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ref_reg       <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= f_valid_reg;
            if (f_valid_reg && f_cmd_reg)
            begin
                ref_reg <= f_angle_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tilt_reg  <= f_angle_reg;
            delta_reg <= delta_next;
            cap_reg   <= f_cmd_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.tilt_angle  = tilt_reg;
    assign result.delta_angle = delta_reg;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !sample.ready)
        else $error("request taken while pipeline stalled");

    a_capture_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cap_reg) |-> (delta_reg == '0))
        else $error("capture result carries nonzero delta");

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (tilt_reg <= AngleW'(AngleLimit))
                          && (tilt_reg >= -AngleW'(AngleLimit)))
        else $error("tilt outside saturation range");

    a_ref_update: assert property (@(posedge clk) disable iff (!rst_n)
        (en && f_valid_reg && f_cmd_reg) |=> (ref_reg == tilt_reg))
        else $error("reference not updated on capture");

endmodule
